[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/ppc_pkg.sv]
// ---------------------------------------------------------------------------
// ppc_pkg
// Types, constants and log-likelihood tables for the consensus column caller.
// ---------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

   localparam int MaxPhred    = 60;
   localparam int LogFracBits = 16;
   localparam int TableTop    = 60;
   localparam int QualTop     = (MaxPhred < TableTop) ? MaxPhred : TableTop;
   localparam int AccW        = 40;
   localparam int ExpCutoff   = 24;

   localparam logic [2:0] BaseN = 3'd4;

   localparam int        CsrIndexW     = 2;
   localparam logic [CsrIndexW-1:0] CSR_ERR_FLOOR = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_QUAL_MIN  = 2'd1;

   localparam logic [30:0] EInvQ32     = 31'd1580030169;
   localparam logic [25:0] TenLog10Q24 = 26'd50504453;

   localparam logic [63:0] Ln4E10      = 64'd13862943611;
   localparam logic [63:0] Ln3E10      = 64'd10986122887;
   localparam logic [63:0] Ln10TenthE10 = 64'd2302585093;
   localparam logic [63:0] UnitE10     = 64'd10000000000;

   localparam logic [63:0] MatchMagE10 [0:TableTop] = '{
      64'd13862943611, 64'd13862943611, 64'd9968430441, 64'd6955244713,
      64'd5076758734, 64'd3801304079, 64'd2892681873, 64'd2225515160,
      64'd1725565729, 64'd1345520003, 64'd1053605157, 64'd827653027,
      64'd651741732, 64'd514182742, 64'd406248442, 64'd321335740,
      64'd254397275, 64'd201543648, 64'd159758692, 64'd126691702,
      64'd100503359, 64'd79749983, 64'd63295629, 64'd50244739,
      64'd39890173, 64'd31672882, 64'd25150465, 64'd19972555,
      64'd15861505, 64'd12597185, 64'd10005003, 64'd7946439,
      64'd6311565, 64'd5013129, 64'd3981864, 64'd3162778,
      64'd2512202, 64'd1995461, 64'd1585019, 64'd1259005,
      64'd1000050, 64'd794360, 64'd630977, 64'd501200,
      64'd398115, 64'd316233, 64'd251192, 64'd199528,
      64'd158491, 64'd125893, 64'd100001, 64'd79433,
      64'd63096, 64'd50119, 64'd39811, 64'd31623,
      64'd25119, 64'd19953, 64'd15849, 64'd12589,
      64'd10000
   };

   typedef logic signed [31:0] ll_row_type [0:TableTop];

   // magnitude in 1e-10 units, rounded half up to Q(LogFracBits), negated
   function automatic ll_row_type build_table(input logic mismatch);
      ll_row_type  r;
      logic [63:0] mag;
      logic [63:0] v;
      for (int q = 0; q <= TableTop; q++) begin
         if (mismatch) begin
            mag = (q < 2) ? Ln4E10 : Ln10TenthE10 * 64'(q) + Ln3E10;
         end else begin
            mag = MatchMagE10[q];
         end
         v    = (mag * (64'd1 << LogFracBits) + UnitE10 / 2) / UnitE10;
         r[q] = -$signed(v[31:0]);
      end
      return r;
   endfunction

   localparam ll_row_type MatchLl    = build_table(1'b0);
   localparam ll_row_type MismatchLl = build_table(1'b1);

   typedef struct packed {
      logic [3:0][AccW-1:0] ll;
      logic                 called;
   } column_type;

   typedef struct packed {
      logic        start;
      logic [35:0] rem_init;
      logic [31:0] dividend;
      logic [34:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

[rtl/ppc_channels.sv]
// ---------------------------------------------------------------------------
// ppc channels
// Valid/ready channel interfaces for read beats, results and CSR writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface ppc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] read_base;
   logic [5:0] read_quality;
   logic       column_end;
   modport source (output valid, read_base, read_quality, column_end, input ready);
   modport sink   (input valid, read_base, read_quality, column_end, output ready);
endinterface

interface ppc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  consensus_base;
   logic [5:0]  consensus_quality;
   logic [31:0] error_prob;
   modport source (output valid, consensus_base, consensus_quality, error_prob,
                   input ready);
   modport sink   (input valid, consensus_base, consensus_quality, error_prob,
                   output ready);
endinterface

interface ppc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ppc_pkg::CsrIndexW-1:0]  index;
   logic [31:0]                    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/ppc_front.sv]
// ---------------------------------------------------------------------------
// ppc_front
// Accumulates per-base log-likelihoods and hands closed columns to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   ppc_req_if.sink                  req,
   input  wire logic                q_full,
   output logic                     push,
   output ppc_pkg::column_type      push_col
);

   logic [3:0][ppc_pkg::AccW-1:0] acc_ff, acc_in, acc_sum;
   logic                          called_ff, called_in;
   logic                          take, hit;
   logic [5:0]                    qi;
   logic signed [31:0]            t_match, t_mis, t_sel;
   logic signed [ppc_pkg::AccW:0] s;

   assign req.ready = !q_full;
   assign take      = req.valid && req.ready;
   assign hit       = take && (req.read_base < 3'd4);
   assign qi        = (req.read_quality > 6'(ppc_pkg::QualTop)) ?
                      6'(ppc_pkg::QualTop) : req.read_quality;
   assign t_match   = ppc_pkg::MatchLl[qi];
   assign t_mis     = ppc_pkg::MismatchLl[qi];

   // saturate below at -2^39; table entries are never positive
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         t_sel = (req.read_base[1:0] == 2'(b)) ? t_match : t_mis;
         s = $signed({acc_ff[b][ppc_pkg::AccW-1], acc_ff[b]}) + 41'(t_sel);
         if (s < -$signed(41'(1) <<< (ppc_pkg::AccW - 1))) begin
            acc_sum[b] = {1'b1, {(ppc_pkg::AccW-1){1'b0}}};
         end else begin
            acc_sum[b] = s[ppc_pkg::AccW-1:0];
         end
      end
   end

   assign push            = take && req.column_end;
   assign push_col.ll     = hit ? acc_sum : acc_ff;
   assign push_col.called = called_ff || hit;

   always_comb begin
      acc_in    = acc_ff;
      called_in = called_ff;
      if (push) begin
         acc_in    = '0;
         called_in = 1'b0;
      end else if (hit) begin
         acc_in    = acc_sum;
         called_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         called_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         called_ff <= called_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ppc_queue.sv]
// ---------------------------------------------------------------------------
// ppc_queue
// Two-entry queue of closed columns between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  ppc_pkg::column_type      push_col,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output ppc_pkg::column_type      head
);

   ppc_pkg::column_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ppc_divider.sv]
// ---------------------------------------------------------------------------
// ppc_divider
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_divider (
   input  wire logic           clock,
   input  wire logic           reset,
   input  ppc_pkg::div_req_type req,
   output ppc_pkg::div_rsp_type rsp
);

   logic [35:0] rem_ff, rem_shift, rem_in;
   logic [31:0] sh_ff, q_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff, ge;

   assign rem_shift = {rem_ff[34:0], sh_ff[31]};
   assign ge        = rem_shift >= {1'b0, req.divisor};
   assign rem_in    = ge ? rem_shift - {1'b0, req.divisor} : rem_shift;

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff  <= req.rem_init;
            sh_ff   <= req.dividend;
            q_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= {sh_ff[30:0], 1'b0};
            q_ff   <= {q_ff[30:0], ge};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

[rtl/ppc_back.sv]
// ---------------------------------------------------------------------------
// ppc_back
// Column posterior sequencer: best base, exp series, p_err division, Phred.
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  ppc_pkg::column_type      head,
   output logic                     pop,
   input  wire logic [31:0]         err_floor,
   input  wire logic [5:0]          qual_min,
   ppc_rsp_if.source                rsp
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_BEST, ST_DIFF, ST_TMUL, ST_TMULW, ST_TDIV, ST_WMUL, ST_WMULW,
      ST_PDIV, ST_PWAIT, ST_RAW, ST_NORM, ST_SQ, ST_SQW, ST_DB, ST_DBW,
      ST_FIN, ST_EMIT
   } state_type;

   localparam int FB = ppc_pkg::LogFracBits;

   state_type                     state_ff;
   logic [3:0][ppc_pkg::AccW-1:0] ll_ff;
   logic [1:0]  best_ff, idx_ff;
   logic [34:0] rest_ff;
   logic [32:0] v_ff, term_ff;
   logic [31:0] frac_ff, p_ff, x_ff, m_ff;
   logic [4:0]  k_ff, whole_ff, n_ff, i_ff;
   logic [23:0] lgf_ff;
   logic        log_sel_ff;
   logic [7:0]  raw_ff;
   logic [6:0]  cap_ff;
   logic [2:0]  res_base_ff;
   logic [5:0]  res_qual_ff;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_base_ff;
   logic [5:0]  rsp_qual_ff;
   logic [31:0] rsp_err_ff;

   logic [32:0] mul_a, mul_b;
   logic [65:0] prod_ff;
   ppc_pkg::div_req_type div_req;
   ppc_pkg::div_rsp_type div_rsp;

   logic signed [ppc_pkg::AccW:0] d;
   logic [32:0] total, mm, vnext;
   logic [29:0] db_arg;
   logic [56:0] db_round;
   logic [7:0]  db_cap, qv;
   logic        out_free;

   ppc_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.consensus_base    = rsp_base_ff;
   assign rsp.consensus_quality = rsp_qual_ff;
   assign rsp.error_prob        = rsp_err_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = (state_ff == ST_IDLE) && head_valid;

   assign d = $signed({ll_ff[best_ff][ppc_pkg::AccW-1], ll_ff[best_ff]})
            - $signed({ll_ff[idx_ff][ppc_pkg::AccW-1], ll_ff[idx_ff]});
   assign total    = {1'b0, p_ff} + {1'b0, err_floor};
   assign mm       = prod_ff[63:31];
   assign db_arg   = 30'(32'd32 << 24) - {1'b0, n_ff, lgf_ff};
   assign db_round = {1'b0, prod_ff[55:0]} + (57'd1 << 47);
   assign db_cap   = 8'(prod_ff[55:48]);
   assign vnext    = k_ff[0] ? v_ff - {1'b0, div_rsp.quotient}
                             : v_ff + {1'b0, div_rsp.quotient};

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_TMUL: begin
            mul_a = term_ff;
            mul_b = {1'b0, frac_ff};
         end
         ST_WMUL: begin
            mul_a = v_ff;
            mul_b = {2'b0, ppc_pkg::EInvQ32};
         end
         ST_SQ: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         ST_DB: begin
            mul_a = {3'b0, db_arg};
            mul_b = {7'b0, ppc_pkg::TenLog10Q24};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_req = '0;
      case (state_ff)
         ST_TMULW: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff[63:32];
         end
         ST_TDIV: begin
            div_req.divisor = 35'(k_ff);
         end
         ST_PDIV: begin
            div_req.start    = 1'b1;
            div_req.rem_init = {1'b0, rest_ff};
         end
         default: begin
            div_req = '0;
         end
      endcase
      if (state_ff == ST_PDIV || state_ff == ST_PWAIT) begin
         div_req.divisor = (35'd1 << 32) + rest_ff;
      end else if (state_ff == ST_TMULW) begin
         div_req.divisor = 35'(k_ff);
      end
   end

   always_comb begin
      qv = (raw_ff < {2'b0, qual_min}) ? {2'b0, qual_min} : raw_ff;
      if (qv > {1'b0, cap_ff}) begin
         qv = {1'b0, cap_ff};
      end
      if (qv > 8'd63) begin
         qv = 8'd63;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  ll_ff   <= head.ll;
                  best_ff <= 2'd0;
                  idx_ff  <= 2'd1;
                  rest_ff <= '0;
                  if (head.called) begin
                     state_ff <= ST_BEST;
                  end else begin
                     res_base_ff <= ppc_pkg::BaseN;
                     res_qual_ff <= 6'd0;
                     p_ff        <= '0;
                     state_ff    <= ST_EMIT;
                  end
               end
            end
            ST_BEST: begin
               if ($signed(ll_ff[idx_ff]) > $signed(ll_ff[best_ff])) begin
                  best_ff <= idx_ff;
               end
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               if (idx_ff == best_ff ||
                   (d >>> FB) >= 41'(ppc_pkg::ExpCutoff)) begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= (idx_ff == 2'd3) ? ST_PDIV : ST_DIFF;
               end else begin
                  whole_ff <= d[FB +: 5];
                  frac_ff  <= {d[FB-1:0], {(32-FB){1'b0}}};
                  v_ff     <= 33'd1 << 32;
                  term_ff  <= 33'd1 << 32;
                  k_ff     <= 5'd1;
                  state_ff <= ST_TMUL;
               end
            end
            ST_TMUL: begin
               state_ff <= ST_TMULW;
            end
            ST_TMULW: begin
               state_ff <= ST_TDIV;
            end
            ST_TDIV: begin
               if (div_rsp.done) begin
                  v_ff    <= vnext;
                  term_ff <= {1'b0, div_rsp.quotient};
                  k_ff    <= k_ff + 5'd1;
                  state_ff <= (k_ff == 5'd16) ? ST_WMUL : ST_TMUL;
               end
            end
            ST_WMUL: begin
               if (whole_ff == 5'd0) begin
                  rest_ff  <= rest_ff + {2'b0, v_ff};
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= (idx_ff == 2'd3) ? ST_PDIV : ST_DIFF;
               end else begin
                  state_ff <= ST_WMULW;
               end
            end
            ST_WMULW: begin
               v_ff     <= prod_ff[64:32];
               whole_ff <= whole_ff - 5'd1;
               state_ff <= ST_WMUL;
            end
            ST_PDIV: begin
               state_ff <= ST_PWAIT;
            end
            ST_PWAIT: begin
               if (div_rsp.done) begin
                  p_ff     <= div_rsp.quotient;
                  state_ff <= ST_RAW;
               end
            end
            ST_RAW: begin
               log_sel_ff <= 1'b0;
               x_ff       <= total[31:0];
               n_ff       <= 5'd31;
               state_ff   <= ST_NORM;
               if (total[32] || total == 33'd0) begin
                  raw_ff <= total[32] ? 8'd0 : 8'd255;
                  log_sel_ff <= 1'b1;
                  x_ff       <= err_floor;
                  if (err_floor == 32'd0) begin
                     cap_ff   <= 7'(ppc_pkg::MaxPhred);
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_NORM: begin
               if (!x_ff[31] && n_ff != 5'd0) begin
                  x_ff <= {x_ff[30:0], 1'b0};
                  n_ff <= n_ff - 5'd1;
               end else begin
                  m_ff     <= x_ff;
                  lgf_ff   <= '0;
                  i_ff     <= '0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               state_ff <= ST_SQW;
            end
            ST_SQW: begin
               lgf_ff   <= {lgf_ff[22:0], mm[32]};
               m_ff     <= mm[32] ? mm[32:1] : mm[31:0];
               i_ff     <= i_ff + 5'd1;
               state_ff <= (i_ff == 5'd23) ? ST_DB : ST_SQ;
            end
            ST_DB: begin
               state_ff <= ST_DBW;
            end
            ST_DBW: begin
               if (!log_sel_ff) begin
                  raw_ff     <= 8'(db_round[56:48]);
                  log_sel_ff <= 1'b1;
                  x_ff       <= err_floor;
                  n_ff       <= 5'd31;
                  if (err_floor == 32'd0) begin
                     cap_ff   <= 7'(ppc_pkg::MaxPhred);
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_NORM;
                  end
               end else begin
                  cap_ff <= (db_cap < 8'(ppc_pkg::MaxPhred)) ?
                            7'(db_cap) : 7'(ppc_pkg::MaxPhred);
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               res_base_ff <= {1'b0, best_ff};
               res_qual_ff <= qv[5:0];
               state_ff    <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_base_ff  <= res_base_ff;
                  rsp_qual_ff  <= res_qual_ff;
                  rsp_err_ff   <= p_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/phred_consensus_column_caller_top.sv]
// ---------------------------------------------------------------------------
// phred_consensus_column_caller_top
// Bayesian per-column base caller with Phred-scaled consensus quality.
// ---------------------------------------------------------------------------
// Each req beat is one read's base and quality for the current column; the
// front adds the table log-likelihoods to four accumulators in the cycle the
// beat is taken, so reads stream at one beat per clock. The beat flagged
// column_end closes the column into a two-entry queue. The back sequencer
// then works the posterior one column at a time on one shared multiplier and
// a bit-serial divider: it picks the best base, then for each other base
// within the cutoff it sums 16 series terms (a multiply, a divider start and
// a divide wait each) and up to 23 exp(-1) multiplies; it then divides for
// p_err and takes up to two log2s (one for the quality, one more for the cap
// when the error floor is nonzero). An empty column gives N, quality 0.
// Reads stall only when two closed columns are already waiting. CSR: index
// 0 error floor (Q0.32), 1 minimum quality; other indexes are ignored. Write
// CSRs only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module phred_consensus_column_caller_top (
   input  wire logic clock,
   input  wire logic reset,
   ppc_req_if.sink   req_bus,
   ppc_rsp_if.source rsp_bus,
   ppc_csr_if.sink   csr_bus
);

   localparam int QualCeil = (ppc_pkg::MaxPhred < 63) ? ppc_pkg::MaxPhred : 63;

   logic [31:0] err_floor_ff;
   logic [5:0]  qual_min_ff;

   logic                push, q_full, pop, head_valid;
   ppc_pkg::column_type push_col, head;

   // CSR writes always accepted
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_floor_ff <= '0;
         qual_min_ff  <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            ppc_pkg::CSR_ERR_FLOOR: err_floor_ff <= csr_bus.data;
            ppc_pkg::CSR_QUAL_MIN:  qual_min_ff  <= csr_bus.data[5:0];
            default: begin
            end
         endcase
      end
   end

   // front: accumulate reads, close columns
   ppc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_col (push_col)
   );

   ppc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_col   (push_col),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: posterior and Phred quality, registered result beat
   ppc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop),
      .err_floor (err_floor_ff),
      .qual_min  (qual_min_ff),
      .rsp       (rsp_bus)
   );

   `PPC_ASSERT_IMPLY(a_n_column_zero, clock, reset,
      rsp_bus.valid && rsp_bus.consensus_base == ppc_pkg::BaseN,
      rsp_bus.consensus_quality == 6'd0 && rsp_bus.error_prob == 32'd0)
   `PPC_ASSERT_IMPLY(a_quality_capped, clock, reset,
      rsp_bus.valid, rsp_bus.consensus_quality <= 6'(QualCeil))
   `PPC_ASSERT_NEXT(a_pop_leaves_idle, clock, reset,
      pop && head.called, !rsp_bus.valid || !pop)

endmodule

`default_nettype wire
